[hdl/bts_pkg.sv]
// bts_pkg: shared types and constants of the bilinear texture sampler
// used by every module of the sampler and by its checker; depends on nothing
package bts_pkg;

   // item kinds on the request channel
   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // one rgb texel, packed red high
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } texel_type;

   // control register indexes
   localparam logic CSR_TEX_WIDTH  = 1'b0;
   localparam logic CSR_TEX_HEIGHT = 1'b1;

   localparam int         CSR_BITS   = 9;
   localparam int         WEIGHT_BITS = 16;
   localparam logic [8:0] SIZE_RESET = 9'd256;

   // words that can be in flight from request to response port
   localparam int PIPE_SLOTS = 6;

endpackage

[hdl/bts_addr.sv]
// bts_addr: coordinate clamp, texel position split and row-major address
// three register stages; depends on bts_pkg
module bts_addr import bts_pkg::*; #(
   parameter  int MAX_WIDTH       = 256,
   parameter  int MAX_HEIGHT      = 256,
   parameter  int COORD_FRAC_BITS = 16,
   localparam int IW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  op_type                 in_op,
   input  logic [15:0]            in_index,
   input  texel_type              in_texel,
   input  logic signed [17:0]     in_u,
   input  logic signed [17:0]     in_v,
   input  logic [CSR_BITS-1:0]    tex_width,
   input  logic [CSR_BITS-1:0]    tex_height,
   output logic                   out_valid,
   input  logic                   out_ready,
   output op_type                 out_op,
   output logic                   out_load_ok,
   output logic [IW-1:0]          out_load_addr,
   output texel_type              out_texel,
   output logic [IW-1:0]          out_base,
   output logic [IW-1:0]          out_row_step,
   output logic                   out_step_x,
   output logic [WEIGHT_BITS-1:0] out_wx,
   output logic [WEIGHT_BITS-1:0] out_wy
);

   localparam int F     = COORD_FRAC_BITS;
   localparam int CW    = F + 1;
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int SW    = $clog2(MAX_WIDTH + 1);
   localparam logic [31:0] DEPTH = 32'(MAX_WIDTH * MAX_HEIGHT);
   localparam logic [31:0] ONE32 = 32'(1) << F;

   function automatic logic [CW-1:0] clamp_coord(input logic signed [17:0] c);
      logic [31:0] mag;
      logic [31:0] r;
      mag = 32'($unsigned(c));
      if (c[17]) r = '0;
      else if (mag > ONE32) r = ONE32;
      else r = mag;
      return r[CW-1:0];
   endfunction

   function automatic logic [31:0] clamp_size(input logic [CSR_BITS-1:0] s,
                                              input int mx);
      logic [31:0] s32;
      logic [31:0] r;
      s32 = 32'(s);
      if (s32 == 32'd0) r = 32'd1;
      else if (s32 > 32'(mx)) r = 32'(mx);
      else r = s32;
      return r;
   endfunction

   // stall chain
   logic en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;
   assign out_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // stage 1: clamp coordinates and sizes, check load address
   logic [31:0]   w32, h32, ix32;
   op_type        op1_ff;
   logic          ok1_ff;
   logic [IW-1:0] la1_ff;
   texel_type     tx1_ff;
   logic [CW-1:0] cu1_ff, cv1_ff;
   logic [SW-1:0] w1_ff;
   logic [XW-1:0] wm1_ff;
   logic [YW-1:0] hm1_ff;

   assign w32  = clamp_size(tex_width, MAX_WIDTH);
   assign h32  = clamp_size(tex_height, MAX_HEIGHT);
   assign ix32 = 32'(in_index);

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff <= in_op;
         ok1_ff <= ix32 < DEPTH;
         la1_ff <= ix32[IW-1:0];
         tx1_ff <= in_texel;
         cu1_ff <= clamp_coord(in_u);
         cv1_ff <= clamp_coord(in_v);
         w1_ff  <= w32[SW-1:0];
         wm1_ff <= XW'(w32 - 32'd1);
         hm1_ff <= YW'(h32 - 32'd1);
      end
   end

   // stage 2: scale by size minus one, split integer and fraction
   logic [CW+XW-1:0] tx_pos;
   logic [CW+YW-1:0] ty_pos;
   logic [F+15:0]    wx_ext, wy_ext;
   op_type           op2_ff;
   logic             ok2_ff;
   logic [IW-1:0]    la2_ff;
   texel_type        tx2_ff;
   logic [SW-1:0]    w2_ff;
   logic [XW-1:0]    x0_ff;
   logic [YW-1:0]    y0_ff;
   logic             sx2_ff, sy2_ff;
   logic [WEIGHT_BITS-1:0] wx2_ff, wy2_ff;

   assign tx_pos = (CW+XW)'(cu1_ff) * (CW+XW)'(wm1_ff);
   assign ty_pos = (CW+YW)'(cv1_ff) * (CW+YW)'(hm1_ff);
   assign wx_ext = {tx_pos[F-1:0], 16'b0};
   assign wy_ext = {ty_pos[F-1:0], 16'b0};

   always_ff @(posedge clock) begin
      if (en2) begin
         op2_ff <= op1_ff;
         ok2_ff <= ok1_ff;
         la2_ff <= la1_ff;
         tx2_ff <= tx1_ff;
         w2_ff  <= w1_ff;
         x0_ff  <= tx_pos[F+XW-1:F];
         y0_ff  <= ty_pos[F+YW-1:F];
         sx2_ff <= |tx_pos[F-1:0];
         sy2_ff <= |ty_pos[F-1:0];
         wx2_ff <= wx_ext[F+15:F];
         wy2_ff <= wy_ext[F+15:F];
      end
   end

   // stage 3: row-major base address and step to the next row
   logic [IW-1:0] base;
   assign base = IW'(y0_ff) * IW'(w2_ff) + IW'(x0_ff);

   always_ff @(posedge clock) begin
      if (en3) begin
         out_op        <= op2_ff;
         out_load_ok   <= ok2_ff;
         out_load_addr <= la2_ff;
         out_texel     <= tx2_ff;
         out_base      <= base;
         out_row_step  <= sy2_ff ? IW'(w2_ff) : '0;
         out_step_x    <= sx2_ff;
         out_wx        <= wx2_ff;
         out_wy        <= wy2_ff;
      end
   end

endmodule

[hdl/bts_store.sv]
// bts_store: texel store in four banks (row copy by index parity)
// one load write or four texel reads per word; depends on bts_pkg
module bts_store import bts_pkg::*; #(
   parameter  int MAX_WIDTH  = 256,
   parameter  int MAX_HEIGHT = 256,
   localparam int IW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  op_type                 in_op,
   input  logic                   in_load_ok,
   input  logic [IW-1:0]          in_load_addr,
   input  texel_type              in_texel,
   input  logic [IW-1:0]          in_base,
   input  logic [IW-1:0]          in_row_step,
   input  logic                   in_step_x,
   input  logic [WEIGHT_BITS-1:0] in_wx,
   input  logic [WEIGHT_BITS-1:0] in_wy,
   output logic                   out_valid,
   input  logic                   out_ready,
   output texel_type              out_t00,
   output texel_type              out_t01,
   output texel_type              out_t10,
   output texel_type              out_t11,
   output logic [WEIGHT_BITS-1:0] out_wx,
   output logic [WEIGHT_BITS-1:0] out_wy
);

   localparam int BD = (MAX_WIDTH * MAX_HEIGHT + 1) / 2;
   localparam int BW = $clog2(BD);

   // even and odd index banks, one copy for the top row, one for the bottom
   texel_type top_even_mem [BD];
   texel_type top_odd_mem  [BD];
   texel_type bot_even_mem [BD];
   texel_type bot_odd_mem  [BD];

   logic          v_ff;
   logic          accept, wr_even, wr_odd;
   logic [BW-1:0] wr_addr;
   logic [IW-1:0] r_top, r_bot;
   logic [BW-1:0] top_even_addr, top_odd_addr, bot_even_addr, bot_odd_addr;
   texel_type     top_even_ff, top_odd_ff, bot_even_ff, bot_odd_ff;
   logic          par_top_ff, par_bot_ff, step_x_ff;

   assign in_ready  = !v_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = v_ff;

   // load write into both copies
   assign wr_even = accept && (in_op == OP_LOAD) && in_load_ok && !in_load_addr[0];
   assign wr_odd  = accept && (in_op == OP_LOAD) && in_load_ok && in_load_addr[0];
   assign wr_addr = BW'(in_load_addr[IW-1:1]);

   // bank addresses of the floor texel and its right neighbour per row
   assign r_top = in_base;
   assign r_bot = in_base + in_row_step;
   assign top_odd_addr  = BW'(r_top[IW-1:1]);
   assign bot_odd_addr  = BW'(r_bot[IW-1:1]);
   assign top_even_addr = BW'(r_top[IW-1:1]) + BW'(r_top[0] & in_step_x);
   assign bot_even_addr = BW'(r_bot[IW-1:1]) + BW'(r_bot[0] & in_step_x);

   always_ff @(posedge clock) begin
      if (wr_even) begin
         top_even_mem[wr_addr] <= in_texel;
         bot_even_mem[wr_addr] <= in_texel;
      end
      if (wr_odd) begin
         top_odd_mem[wr_addr] <= in_texel;
         bot_odd_mem[wr_addr] <= in_texel;
      end
      if (in_ready) begin
         top_even_ff <= top_even_mem[top_even_addr];
         top_odd_ff  <= top_odd_mem[top_odd_addr];
         bot_even_ff <= bot_even_mem[bot_even_addr];
         bot_odd_ff  <= bot_odd_mem[bot_odd_addr];
         par_top_ff  <= r_top[0];
         par_bot_ff  <= r_bot[0];
         step_x_ff   <= in_step_x;
         out_wx      <= in_wx;
         out_wy      <= in_wy;
      end
   end

   // only sample words go on
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid && (in_op == OP_SAMPLE);
      end
   end

   // undo the parity swap
   assign out_t00 = par_top_ff ? top_odd_ff : top_even_ff;
   assign out_t10 = par_bot_ff ? bot_odd_ff : bot_even_ff;
   assign out_t01 = step_x_ff ? (par_top_ff ? top_even_ff : top_odd_ff) : out_t00;
   assign out_t11 = step_x_ff ? (par_bot_ff ? bot_even_ff : bot_odd_ff) : out_t10;

endmodule

[hdl/bts_blend.sv]
// bts_blend: horizontal then vertical weighted blend, output register
// two register stages; depends on bts_pkg
module bts_blend import bts_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  texel_type              in_t00,
   input  texel_type              in_t01,
   input  texel_type              in_t10,
   input  texel_type              in_t11,
   input  logic [WEIGHT_BITS-1:0] in_wx,
   input  logic [WEIGHT_BITS-1:0] in_wy,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [15:0]            out_red,
   output logic [15:0]            out_green,
   output logic [15:0]            out_blue
);

   // byte blend, result byte.16
   function automatic logic [23:0] lerp_h(input logic [7:0] a, input logic [7:0] b,
                                          input logic [WEIGHT_BITS-1:0] w);
      logic [16:0] wi;
      logic [24:0] s;
      wi = 17'h10000 - {1'b0, w};
      s  = 25'(a) * 25'(wi) + 25'(b) * 25'(w);
      return s[23:0];
   endfunction

   // byte.16 blend, result byte.8 truncated
   function automatic logic [15:0] lerp_v(input logic [23:0] a, input logic [23:0] b,
                                          input logic [WEIGHT_BITS-1:0] w);
      logic [16:0] wi;
      logic [40:0] s;
      wi = 17'h10000 - {1'b0, w};
      s  = 41'(a) * 41'(wi) + 41'(b) * 41'(w);
      return s[39:24];
   endfunction

   logic        v1_ff, vo_ff, en1, eno;
   logic [23:0] top_r_ff, top_g_ff, top_b_ff, bot_r_ff, bot_g_ff, bot_b_ff;
   logic [WEIGHT_BITS-1:0] wy_ff;

   assign eno       = !vo_ff || out_ready;
   assign en1       = !v1_ff || eno;
   assign in_ready  = en1;
   assign out_valid = vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (eno) vo_ff <= v1_ff;
      end
   end

   // horizontal blend of both rows
   always_ff @(posedge clock) begin
      if (en1) begin
         top_r_ff <= lerp_h(in_t00.red,   in_t01.red,   in_wx);
         top_g_ff <= lerp_h(in_t00.green, in_t01.green, in_wx);
         top_b_ff <= lerp_h(in_t00.blue,  in_t01.blue,  in_wx);
         bot_r_ff <= lerp_h(in_t10.red,   in_t11.red,   in_wx);
         bot_g_ff <= lerp_h(in_t10.green, in_t11.green, in_wx);
         bot_b_ff <= lerp_h(in_t10.blue,  in_t11.blue,  in_wx);
         wy_ff    <= in_wy;
      end
   end

   // vertical blend into the output register
   always_ff @(posedge clock) begin
      if (eno) begin
         out_red   <= lerp_v(top_r_ff, bot_r_ff, wy_ff);
         out_green <= lerp_v(top_g_ff, bot_g_ff, wy_ff);
         out_blue  <= lerp_v(top_b_ff, bot_b_ff, wy_ff);
      end
   end

endmodule

[hdl/bilinear_texture_sampler.sv]
// Bilinear RGB texture sampler. A load word (op 0) writes one texel at a
// row-major index; a sample word (op 1) clamps u,v to [0,1], scales them by
// width-1 and height-1 and returns the bilinear blend of the four texels as
// byte.8 per channel. The pipeline takes one word per cycle with no stall
// from the other side; a sample passes six register stages on its way to
// the response: three address stages, the banked store read, two blend
// stages. Four texels are read per cycle from four single-read-port banks:
// two row copies, each split by index parity. Store content is undefined
// until loaded. Width and height are written through the csr port; the user
// must write them only while idle, as the block itself does not enforce it.
module bilinear_texture_sampler import bts_pkg::*; #(
   parameter int MAX_WIDTH       = 256,
   parameter int MAX_HEIGHT      = 256,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [15:0]         req_texel_index,
   input  logic [7:0]          req_load_red,
   input  logic [7:0]          req_load_green,
   input  logic [7:0]          req_load_blue,
   input  logic signed [17:0]  req_coord_u,
   input  logic signed [17:0]  req_coord_v,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_red,
   output logic [15:0]         rsp_green,
   output logic [15:0]         rsp_blue,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CSR_BITS-1:0] csr_wdata
);

   localparam int IW = $clog2(MAX_WIDTH * MAX_HEIGHT);

   // size registers
   logic [CSR_BITS-1:0] tex_width_ff, tex_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= SIZE_RESET;
         tex_height_ff <= SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:  tex_width_ff  <= csr_wdata;
            CSR_TEX_HEIGHT: tex_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   texel_type req_texel;
   assign req_texel = '{red: req_load_red, green: req_load_green, blue: req_load_blue};

   // address stages
   logic                   a_valid, a_ready, a_load_ok, a_step_x;
   op_type                 a_op;
   logic [IW-1:0]          a_load_addr, a_base, a_row_step;
   texel_type              a_texel;
   logic [WEIGHT_BITS-1:0] a_wx, a_wy;

   bts_addr #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_addr (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_op(op_type'(req_op)), .in_index(req_texel_index), .in_texel(req_texel),
      .in_u(req_coord_u), .in_v(req_coord_v),
      .tex_width(tex_width_ff), .tex_height(tex_height_ff),
      .out_valid(a_valid), .out_ready(a_ready),
      .out_op(a_op), .out_load_ok(a_load_ok), .out_load_addr(a_load_addr),
      .out_texel(a_texel), .out_base(a_base), .out_row_step(a_row_step),
      .out_step_x(a_step_x), .out_wx(a_wx), .out_wy(a_wy)
   );

   // texel store
   logic                   s_valid, s_ready;
   texel_type              s_t00, s_t01, s_t10, s_t11;
   logic [WEIGHT_BITS-1:0] s_wx, s_wy;

   bts_store #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
   ) u_store (
      .clock(clock), .reset(reset),
      .in_valid(a_valid), .in_ready(a_ready),
      .in_op(a_op), .in_load_ok(a_load_ok), .in_load_addr(a_load_addr),
      .in_texel(a_texel), .in_base(a_base), .in_row_step(a_row_step),
      .in_step_x(a_step_x), .in_wx(a_wx), .in_wy(a_wy),
      .out_valid(s_valid), .out_ready(s_ready),
      .out_t00(s_t00), .out_t01(s_t01), .out_t10(s_t10), .out_t11(s_t11),
      .out_wx(s_wx), .out_wy(s_wy)
   );

   // blend and output register
   bts_blend u_blend (
      .clock(clock), .reset(reset),
      .in_valid(s_valid), .in_ready(s_ready),
      .in_t00(s_t00), .in_t01(s_t01), .in_t10(s_t10), .in_t11(s_t11),
      .in_wx(s_wx), .in_wy(s_wy),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_red(rsp_red), .out_green(rsp_green), .out_blue(rsp_blue)
   );

endmodule

[hdl/bts_checker.sv]
// bts_checker: port-level assertions for the texture sampler, with its bind
// depends on bts_pkg and the ports of bilinear_texture_sampler
module bts_checker import bts_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_op,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_red,
   input logic [15:0] rsp_green,
   input logic [15:0] rsp_blue
);

   // samples accepted but not yet answered
   logic [3:0] pending_ff;
   logic       inc, dec;
   assign inc = req_valid && req_ready && (op_type'(req_op) == OP_SAMPLE);
   assign dec = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 4'(inc) - 4'(dec);
      end
   end

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) &&
      $stable(rsp_green) && $stable(rsp_blue))
      else $error("response word changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // no response without an outstanding sample
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response without a pending sample");

   // pipeline never holds more samples than it has slots
   a_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'(PIPE_SLOTS))
      else $error("more samples in flight than pipeline slots");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue)
);
